>>> design/pce_pkg.sv
// Package for the perpendicular celtic escape-time block.
// Holds fixed-point widths, register indexes, shared structs and the coordinate
// saturation function. No dependencies.
`default_nettype none

package pce_pkg;

   parameter int FRAC_BITS  = 28;
   parameter int COORD_W    = 32;
   parameter int PROD_W     = 2 * COORD_W;
   // |v|^2 is at most 2^(2*COORD_W-2), so it fits in PROD_W-1 bits
   parameter int SQ_W       = PROD_W - 1 - FRAC_BITS;
   parameter int SUM_W      = SQ_W + 1;
   parameter int CROSS_W    = PROD_W - FRAC_BITS;
   parameter int NXT_W      = CROSS_W + 2;
   parameter int ITER_W     = 16;
   parameter int MAG_W      = 38;
   parameter int CSR_IDX_W  = 2;
   parameter int CSR_DATA_W = 32;

   parameter logic [CSR_IDX_W-1:0] CSR_C_REAL = 2'd0;
   parameter logic [CSR_IDX_W-1:0] CSR_C_IMAG = 2'd1;
   parameter logic [CSR_IDX_W-1:0] CSR_LIMIT  = 2'd2;

   parameter logic [ITER_W-1:0] LIMIT_RESET = 16'd100;

   // escape when x^2 + y^2 > 4.0
   parameter logic [SUM_W-1:0] ESC_THRESH = SUM_W'(4) << FRAC_BITS;

   parameter logic signed [NXT_W-1:0] SAT_HI = (NXT_W'(1) << (COORD_W - 1)) - NXT_W'(1);
   parameter logic signed [NXT_W-1:0] SAT_LO = -(NXT_W'(1) << (COORD_W - 1));

   typedef struct packed {
      logic signed [COORD_W-1:0] c_real;
      logic signed [COORD_W-1:0] c_imag;
      logic [ITER_W-1:0]         limit;
   } pce_cfg_type;

   typedef struct packed {
      logic [ITER_W-1:0] index;
      logic              escaped;
      logic [MAG_W-1:0]  mag;
   } pce_result_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [NXT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < SAT_LO) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/pce_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on pce_pkg for operand and product widths.
`default_nettype none

module pce_mul (
   input  wire logic                          clock,
   input  wire logic [pce_pkg::COORD_W-1:0]   op_a,
   input  wire logic [pce_pkg::COORD_W-1:0]   op_b,
   output logic      [pce_pkg::PROD_W-1:0]    prod
);

   logic [pce_pkg::PROD_W-1:0] prod_ff;
   logic [pce_pkg::PROD_W-1:0] prod_in;

   assign prod_in = pce_pkg::PROD_W'(op_a) * pce_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> design/pce_core.sv
// Iteration sequencer and datapath: squares, cross term, escape test, update.
// Depends on pce_pkg and pce_mul (one multiplier shared by all products).
`default_nettype none

module pce_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pce_pkg::pce_cfg_type               cfg,
   input  wire logic                               start_valid,
   output logic                                    start_ready,
   input  wire logic signed [pce_pkg::COORD_W-1:0] start_x,
   input  wire logic signed [pce_pkg::COORD_W-1:0] start_y,
   output logic                                    res_valid,
   input  wire logic                               res_ready,
   output pce_pkg::pce_result_type                 result
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQX  = 6'b000010,
      ST_SQY  = 6'b000100,
      ST_EVAL = 6'b001000,
      ST_UPD  = 6'b010000,
      ST_DONE = 6'b100000
   } pce_state_type;

   pce_state_type state_ff, state_in;

   logic signed [pce_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [pce_pkg::SQ_W-1:0]           sx_ff, sx_in, absd_ff, absd_in;
   logic [pce_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [pce_pkg::ITER_W-1:0]         cnt_ff, cnt_in;
   logic                               first_ff, first_in;
   logic                               esc_ff, esc_in;

   logic [pce_pkg::COORD_W-1:0] mx, my, op_a, op_b;
   logic [pce_pkg::PROD_W-1:0]  prod;

   logic [pce_pkg::SQ_W-1:0]          sq_now;
   logic [pce_pkg::SUM_W-1:0]         sum_now;
   logic signed [pce_pkg::SUM_W-1:0]  diff;
   logic [pce_pkg::ITER_W-1:0]        cnt_next;
   logic [pce_pkg::CROSS_W-1:0]       cross_mag;
   logic signed [pce_pkg::NXT_W-1:0]  cross_term, ny_wide, nx_wide;
   logic signed [pce_pkg::NXT_W-1:0]  c_imag_wide, c_real_wide;

   assign mx = x_ff[pce_pkg::COORD_W-1] ? pce_pkg::COORD_W'(-x_ff) : x_ff;
   assign my = y_ff[pce_pkg::COORD_W-1] ? pce_pkg::COORD_W'(-y_ff) : y_ff;

   // SQX issues |x|^2, SQY issues |y|^2, EVAL issues |x|*|y| for the next update
   always_comb begin
      op_a = mx;
      op_b = my;
      case (state_ff)
         ST_SQX: begin
            op_a = mx;
            op_b = mx;
         end
         ST_SQY: begin
            op_a = my;
            op_b = my;
         end
         default: begin
            op_a = mx;
            op_b = my;
         end
      endcase
   end

   pce_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign sq_now    = prod[pce_pkg::FRAC_BITS +: pce_pkg::SQ_W];
   assign sum_now   = pce_pkg::SUM_W'(sx_ff) + pce_pkg::SUM_W'(sq_now);
   assign diff      = $signed({1'b0, sx_ff}) - $signed({1'b0, sq_now});
   assign cnt_next  = first_ff ? cnt_ff : cnt_ff + pce_pkg::ITER_W'(1);

   // 2|x||y| truncated, sign opposite to y
   assign cross_mag  = prod[(pce_pkg::FRAC_BITS-1) +: pce_pkg::CROSS_W];
   assign cross_term = y_ff[pce_pkg::COORD_W-1] ? $signed({2'b00, cross_mag})
                                                : -$signed({2'b00, cross_mag});
   assign c_imag_wide = {{(pce_pkg::NXT_W-pce_pkg::COORD_W){cfg.c_imag[pce_pkg::COORD_W-1]}},
                         cfg.c_imag};
   assign c_real_wide = {{(pce_pkg::NXT_W-pce_pkg::COORD_W){cfg.c_real[pce_pkg::COORD_W-1]}},
                         cfg.c_real};
   assign ny_wide   = cross_term + c_imag_wide;
   assign nx_wide   = $signed({{(pce_pkg::NXT_W-pce_pkg::SQ_W){1'b0}}, absd_ff}) + c_real_wide;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      sx_in    = sx_ff;
      absd_in  = absd_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      esc_in   = esc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_valid) begin
               x_in     = start_x;
               y_in     = start_y;
               cnt_in   = '0;
               first_in = 1'b1;
               esc_in   = 1'b0;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sx_in    = sq_now;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            sum_in  = sum_now;
            absd_in = diff[pce_pkg::SUM_W-1] ? pce_pkg::SQ_W'(-diff) : pce_pkg::SQ_W'(diff);
            if (!first_ff && (sum_now > pce_pkg::ESC_THRESH)) begin
               esc_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_next;
               first_in = 1'b0;
               state_in = (cnt_next < cfg.limit) ? ST_UPD : ST_DONE;
            end
         end
         ST_UPD: begin
            x_in     = pce_pkg::sat_coord(nx_wide);
            y_in     = pce_pkg::sat_coord(ny_wide);
            state_in = ST_SQX;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      sx_ff    <= sx_in;
      absd_ff  <= absd_in;
      sum_ff   <= sum_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
      esc_ff   <= esc_in;
   end

   assign start_ready    = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_DONE);
   assign result.index   = cnt_ff;
   assign result.escaped = esc_ff;
   assign result.mag     = pce_pkg::MAG_W'(sum_ff);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= cfg.limit))
      else $error("iteration count beyond limit");

   a_bounded_index: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !result.escaped) |-> (result.index == cfg.limit))
      else $error("bounded result index differs from limit");

   a_escape_mag: assert property (@(posedge clock) disable iff (reset)
      (res_valid && result.escaped) |-> (sum_ff > pce_pkg::ESC_THRESH))
      else $error("escaped result with magnitude under threshold");

endmodule

`default_nettype wire

>>> design/perpendicular_celtic_escape_time.sv
// Perpendicular celtic escape-time engine: one request in, one result out.
// Each map iteration steps through SQX, SQY, EVAL and UPD on the one shared 32x32
// multiplier (|x|^2, |y|^2, |x|*|y|, then the coordinate update), and at most limit
// iterations run. A new request is taken only once the previous result has moved
// to the output register. Reset (synchronous, active high) clears the sequencer and
// output valid; c_real and c_imag reset to 0, iteration_limit to 100.
`default_nettype none

module perpendicular_celtic_escape_time (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] start_real, [63:32] start_imag
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [15:0] iteration_index, [53:16] magnitude_squared
   output logic [0:0]       rsp_tuser,   // [0] escaped
   input  wire logic                                csr_we,
   input  wire logic [pce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pce_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   pce_pkg::pce_cfg_type    cfg_ff, cfg_in;
   pce_pkg::pce_result_type core_result;
   pce_pkg::pce_result_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    core_res_valid, core_res_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pce_pkg::CSR_C_REAL: cfg_in.c_real = csr_wdata[pce_pkg::COORD_W-1:0];
            pce_pkg::CSR_C_IMAG: cfg_in.c_imag = csr_wdata[pce_pkg::COORD_W-1:0];
            pce_pkg::CSR_LIMIT:  cfg_in.limit  = csr_wdata[pce_pkg::ITER_W-1:0];
            default:             cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real <= '0;
         cfg_ff.c_imag <= '0;
         cfg_ff.limit  <= pce_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pce_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start_valid (req_tvalid),
      .start_ready (req_tready),
      .start_x     (req_tdata[31:0]),
      .start_y     (req_tdata[63:32]),
      .res_valid   (core_res_valid),
      .res_ready   (core_res_ready),
      .result      (core_result)
   );

   // output register decouples the core from the result consumer
   assign core_res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (core_res_valid && core_res_ready) begin
         rsp_in       = core_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.mag, rsp_ff.index};
   assign rsp_tuser  = rsp_ff.escaped;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous item in flight");

   a_rsvd_index: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index != pce_pkg::CSR_C_REAL) && (csr_index != pce_pkg::CSR_C_IMAG)
       && (csr_index != pce_pkg::CSR_LIMIT)) |=> (cfg_ff == $past(cfg_ff)))
      else $error("write to unused register index changed configuration");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !core_res_valid) |=> !rsp_tvalid)
      else $error("result repeated after it was taken");

endmodule

`default_nettype wire
